>>> rtl/core/sctg_pkg.sv
// ----------------------------------------------------------------------------
// sctg_pkg
// Shared types, register codes and the arithmetic helper of the shaped CW I/Q
// tone generator.
// ----------------------------------------------------------------------------
`default_nettype none

package sctg_pkg;

    localparam int unsigned WINDOW_DEPTH_DEF = 1024;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned LEN_W      = 11;
    localparam int unsigned CNT_W      = 24;
    localparam int unsigned WVAL_W     = 15;
    localparam int unsigned WIDX_W     = 10;
    localparam int unsigned SMP_W      = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VOLUME        = 3'd0,
        CFG_IQ_GAIN       = 3'd1,
        CFG_IQ_PHASE      = 3'd2,
        CFG_STEP_COS      = 3'd3,
        CFG_STEP_SIN      = 3'd4,
        CFG_WINDOW_LENGTH = 3'd5
    } t_cfg_idx;

    localparam logic [14:0]        VOLUME_RST   = 15'd32767;
    localparam logic signed [15:0] IQ_GAIN_RST  = 16'sd16384;
    localparam logic signed [15:0] IQ_PHASE_RST = 16'sd0;
    localparam logic signed [15:0] STEP_COS_RST = 16'sd32767;
    localparam logic signed [15:0] STEP_SIN_RST = 16'sd0;
    localparam logic [LEN_W-1:0]   WIN_LEN_RST  = '0;
    localparam logic signed [15:0] OSC_RE_RST   = 16'sd32767;
    localparam logic signed [15:0] OSC_IM_RST   = 16'sd0;

    typedef struct packed {
        logic [14:0]        volume;
        logic signed [15:0] iq_gain;
        logic signed [15:0] iq_phase;
        logic signed [15:0] step_cos;
        logic signed [15:0] step_sin;
        logic [LEN_W-1:0]   window_length;
    } t_cfg;

    typedef struct packed {
        logic              mode;
        logic [WIDX_W-1:0] window_index;
        logic [WVAL_W-1:0] window_value;
        logic [CNT_W-1:0]  add_samples;
    } t_in_req;

    typedef struct packed {
        logic signed [SMP_W-1:0] i_sample;
        logic signed [SMP_W-1:0] q_sample;
        logic                    tone_active;
    } t_out_rsp;

    function automatic logic signed [15:0] sat16(input logic signed [18:0] x);
        logic signed [15:0] r;
        if (x > 19'sd32767) begin
            r = 16'sd32767;
        end else if (x < -19'sd32768) begin
            r = -16'sd32768;
        end else begin
            r = x[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/shaped_cw_iq_tone_generator.sv
// ----------------------------------------------------------------------------
// shaped_cw_iq_tone_generator
// Keyed CW carrier with windowed envelope and IQ-imbalance correction.
//
// Channels: the input request carries either a tick (mode 0, adds tone
// samples to the remaining count) or a window table write (mode 1). Each
// tick request gives exactly one output request with the corrected I/Q
// sample and the tone_active flag; a table write gives none. The config
// channel writes one register per request and is always ready; it is to be
// used only while no tick is in flight.
// Sequencing: a keyed or ramping-down tick walks the single sequencer through
// the rotation, oscillator, envelope, rounding, correction and done states before
// its result enters the output register; any other tick goes straight to done.
// Requests are accepted only with the sequencer idle, so no tick is taken before
// the last is through; table writes are taken one per cycle while it is idle.
// Reset: oscillator at unit magnitude, count and window position zero,
// registers at their defaults; the window table is not cleared.
// Stall: one result waits in the output register while the next request is
// taken and computed; it then waits until the held result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module shaped_cw_iq_tone_generator #(
    parameter int unsigned WINDOW_DEPTH = sctg_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [sctg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [sctg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire sctg_pkg::t_in_req               i_in_req,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output sctg_pkg::t_out_rsp                   o_out_rsp
);
    import sctg_pkg::*;

    localparam int unsigned AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    t_cfg              cfg;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WVAL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [WVAL_W-1:0] ram_rdata;

    assign o_cfg_ready = 1'b1;

    sctg_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    sctg_win_ram #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sctg_engine #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

endmodule

`default_nettype wire

>>> rtl/core/sctg_cfg_regs.sv
// ----------------------------------------------------------------------------
// sctg_cfg_regs
// Configuration register file, written by index through the config channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sctg_cfg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_we,
    input  wire logic [sctg_pkg::CFG_IDX_W-1:0]  i_index,
    input  wire logic [sctg_pkg::CFG_DATA_W-1:0] i_data,
    output sctg_pkg::t_cfg                       o_cfg
);
    import sctg_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.volume        <= VOLUME_RST;
            r_cfg.iq_gain       <= IQ_GAIN_RST;
            r_cfg.iq_phase      <= IQ_PHASE_RST;
            r_cfg.step_cos      <= STEP_COS_RST;
            r_cfg.step_sin      <= STEP_SIN_RST;
            r_cfg.window_length <= WIN_LEN_RST;
        end else if (i_we) begin
            case (i_index)
                CFG_VOLUME:        r_cfg.volume        <= i_data[14:0];
                CFG_IQ_GAIN:       r_cfg.iq_gain       <= $signed(i_data);
                CFG_IQ_PHASE:      r_cfg.iq_phase      <= $signed(i_data);
                CFG_STEP_COS:      r_cfg.step_cos      <= $signed(i_data);
                CFG_STEP_SIN:      r_cfg.step_sin      <= $signed(i_data);
                CFG_WINDOW_LENGTH: r_cfg.window_length <= i_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> rtl/core/sctg_win_ram.sv
// ----------------------------------------------------------------------------
// sctg_win_ram
// Window table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module sctg_win_ram #(
    parameter int unsigned DEPTH = sctg_pkg::WINDOW_DEPTH_DEF,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [AW-1:0]                 i_waddr,
    input  wire logic [sctg_pkg::WVAL_W-1:0]   i_wdata,
    input  wire logic                          i_re,
    input  wire logic [AW-1:0]                 i_raddr,
    output logic [sctg_pkg::WVAL_W-1:0]        o_rdata
);
    import sctg_pkg::*;

    logic [WVAL_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sctg_engine.sv
// ----------------------------------------------------------------------------
// sctg_engine
// Per-tick sequencer: count and window position update, window table read,
// oscillator rotation, envelope scaling, IQ correction and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sctg_engine #(
    parameter int unsigned DEPTH = sctg_pkg::WINDOW_DEPTH_DEF,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire sctg_pkg::t_cfg              i_cfg,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire sctg_pkg::t_in_req           i_in_req,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output sctg_pkg::t_out_rsp               o_out_rsp,
    output logic                             o_ram_we,
    output logic [AW-1:0]                    o_ram_waddr,
    output logic [sctg_pkg::WVAL_W-1:0]      o_ram_wdata,
    output logic                             o_ram_re,
    output logic [AW-1:0]                    o_ram_raddr,
    input  wire logic [sctg_pkg::WVAL_W-1:0] i_ram_rdata
);
    import sctg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_ROT,
        S_OSC,
        S_MUL_AMP,
        S_ROUND,
        S_MUL_IQ,
        S_DONE
    } t_state;

    t_state r_state;

    logic signed [15:0] r_osc_re;
    logic signed [15:0] r_osc_im;
    logic [CNT_W-1:0]   r_count;
    logic [LEN_W-1:0]   r_pos;
    logic               r_act;
    logic               r_ramp;

    logic signed [31:0] r_p0, r_p1, r_p2, r_p3;
    logic [29:0]        r_amp_p;
    logic [14:0]        r_amp;
    logic signed [31:0] r_tre_p, r_tim_p;
    logic signed [16:0] r_tre, r_tim;
    logic signed [32:0] r_gain_p, r_phase_p;

    logic               r_out_valid;
    t_out_rsp           r_out;

    // request decode and state update at acceptance
    logic               in_acc;
    logic               tick_acc;
    logic [CNT_W:0]     cnt_sum;
    logic [CNT_W-1:0]   cnt_sat;
    logic [LEN_W-1:0]   eff_len;
    logic               tone;
    logic               ramp_up;
    logic               ramp_down;
    logic [CNT_W-1:0]   n_count;
    logic [LEN_W-1:0]   n_pos;
    logic [LEN_W-1:0]   pos_dec;

    assign in_acc   = i_in_valid && o_in_ready;
    assign tick_acc = in_acc && !i_in_req.mode;
    assign cnt_sum  = {1'b0, r_count} + {1'b0, i_in_req.add_samples};
    assign cnt_sat  = cnt_sum[CNT_W] ? '1 : cnt_sum[CNT_W-1:0];
    assign eff_len  = (32'(i_cfg.window_length) > 32'(DEPTH)) ? LEN_W'(DEPTH)
                                                               : i_cfg.window_length;
    assign tone      = (cnt_sat != '0);
    assign ramp_up   = tone && (r_pos < eff_len);
    assign ramp_down = !tone && (r_pos != '0);
    assign pos_dec   = r_pos - LEN_W'(1);
    assign n_count   = tone ? cnt_sat - CNT_W'(1) : cnt_sat;
    assign n_pos     = ramp_up ? r_pos + LEN_W'(1) : (ramp_down ? pos_dec : r_pos);

    assign o_ram_we    = in_acc && i_in_req.mode && (32'(i_in_req.window_index) < 32'(DEPTH));
    assign o_ram_waddr = AW'(i_in_req.window_index);
    assign o_ram_wdata = i_in_req.window_value;
    assign o_ram_re    = tick_acc;
    assign o_ram_raddr = ramp_down ? AW'(pos_dec) : AW'(r_pos);

    // rotation sums
    logic signed [32:0] re_sum, im_sum, re_rnd, im_rnd;
    assign re_sum = 33'(r_p0) - 33'(r_p1);
    assign im_sum = 33'(r_p2) + 33'(r_p3);
    assign re_rnd = (re_sum + 33'sd16384) >>> 15;
    assign im_rnd = (im_sum + 33'sd16384) >>> 15;

    logic [30:0] amp_sum;
    assign amp_sum = {1'b0, r_amp_p} + 31'd16384;

    logic signed [32:0] tre_sum, tim_sum, tre_rnd, tim_rnd;
    assign tre_sum = (33'(r_tre_p) + 33'sd16384) >>> 15;
    assign tim_sum = (33'(r_tim_p) + 33'sd16384) >>> 15;
    assign tre_rnd = tre_sum;
    assign tim_rnd = tim_sum;

    // iq correction
    logic signed [33:0] gain_rnd, phase_rnd;
    logic signed [18:0] q_pre;
    t_out_rsp           n_out;
    assign gain_rnd  = (34'(r_gain_p) + 34'sd8192) >>> 14;
    assign phase_rnd = (34'(r_phase_p) + 34'sd16384) >>> 15;
    assign q_pre     = $signed(phase_rnd[18:0]) + 19'(r_tre);

    always_comb begin
        if (r_act) begin
            n_out.i_sample    = sat16($signed(gain_rnd[18:0]));
            n_out.q_sample    = sat16(q_pre);
            n_out.tone_active = 1'b1;
        end else begin
            n_out.i_sample    = '0;
            n_out.q_sample    = '0;
            n_out.tone_active = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_osc_re    <= OSC_RE_RST;
            r_osc_im    <= OSC_IM_RST;
            r_count     <= '0;
            r_pos       <= '0;
            r_act       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (tick_acc) begin
                        r_count <= n_count;
                        r_pos   <= n_pos;
                        r_act   <= tone || ramp_down;
                        r_ramp  <= ramp_up || ramp_down;
                        r_state <= (tone || ramp_down) ? S_MUL_ROT : S_DONE;
                    end
                end
                S_MUL_ROT: begin
                    r_p0    <= r_osc_re * i_cfg.step_cos;
                    r_p1    <= r_osc_im * i_cfg.step_sin;
                    r_p2    <= r_osc_re * i_cfg.step_sin;
                    r_p3    <= r_osc_im * i_cfg.step_cos;
                    r_amp_p <= i_ram_rdata * i_cfg.volume;
                    r_state <= S_OSC;
                end
                S_OSC: begin
                    r_osc_re <= sat16(re_rnd[18:0]);
                    r_osc_im <= sat16(im_rnd[18:0]);
                    r_amp    <= r_ramp ? amp_sum[29:15] : i_cfg.volume;
                    r_state  <= S_MUL_AMP;
                end
                S_MUL_AMP: begin
                    r_tre_p <= r_osc_re * $signed({1'b0, r_amp});
                    r_tim_p <= r_osc_im * $signed({1'b0, r_amp});
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_tre   <= tre_rnd[16:0];
                    r_tim   <= tim_rnd[16:0];
                    r_state <= S_MUL_IQ;
                end
                S_MUL_IQ: begin
                    r_gain_p  <= r_tim * i_cfg.iq_gain;
                    r_phase_p <= r_tim * i_cfg.iq_phase;
                    r_state   <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out       <= n_out;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

endmodule

`default_nettype wire

>>> rtl/core/sctg_checker.sv
// ----------------------------------------------------------------------------
// sctg_checker
// Port-level checks of the tone generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sctg_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_cfg_valid,
    input wire logic                            o_cfg_ready,
    input wire logic [sctg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input wire logic [sctg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_ready,
    input wire sctg_pkg::t_in_req               i_in_req,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_ready,
    input wire sctg_pkg::t_out_rsp              o_out_rsp
);
    import sctg_pkg::*;

    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_rsp))
        else $error("output request dropped or changed while stalled");

    a_silent_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_rsp.tone_active |->
            o_out_rsp.i_sample == '0 && o_out_rsp.q_sample == '0)
        else $error("silent sample is not zero");

    a_tick_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_in_req.mode |=> !o_in_ready)
        else $error("tick request accepted without busy interval");

    a_load_no_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_req.mode && !o_out_valid |=> !o_out_valid)
        else $error("table write produced an output request");

    a_cfg_write : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready && !$isunknown({i_cfg_index, i_cfg_data}))
        else $error("config request refused or unknown");

endmodule

bind shaped_cw_iq_tone_generator sctg_checker u_sctg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_index (i_cfg_index),
    .i_cfg_data  (i_cfg_data),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_req    (i_in_req),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_rsp   (o_out_rsp)
);

`default_nettype wire

>>> tb/shaped_cw_iq_tone_generator_test.sv
// ----------------------------------------------------------------------------
// shaped_cw_iq_tone_generator_test
// Self-checking testbench of the shaped CW I/Q tone generator. A built-in
// model of the oscillator, envelope, tone counter and IQ correction predicts
// every output request. Directed tests cover silence, ramps, held tone,
// register extremes and a window shortened mid-tone. Longer tests cover a
// long window ramp, random traffic under three idle profiles, a long output
// stall and a saturated tone counter.
// ----------------------------------------------------------------------------
`default_nettype none

module shaped_cw_iq_tone_generator_test;

    import sctg_pkg::*;

    localparam int unsigned TAB_DEPTH     = WINDOW_DEPTH_DEF;
    localparam int unsigned LONG_WIN      = 32;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned HOLD_CYCLES   = 200;
    localparam int unsigned QUIET_LIMIT   = 2000;
    localparam logic        MODE_TICK     = 1'b0;
    localparam logic        MODE_LOAD     = 1'b1;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [2:0] i_cfg_index = CFG_VOLUME;
    logic [15:0] i_cfg_data = '0;
    logic       i_in_valid  = 1'b0;
    t_in_req    i_in_req    = '0;
    logic       i_out_ready = 1'b0;
    logic       o_cfg_ready;
    logic       o_in_ready;
    logic       o_out_valid;
    t_out_rsp   o_out_rsp;

    shaped_cw_iq_tone_generator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // model state
    t_cfg cfg_shadow = '{volume: VOLUME_RST, iq_gain: IQ_GAIN_RST, iq_phase: IQ_PHASE_RST,
                         step_cos: STEP_COS_RST, step_sin: STEP_SIN_RST,
                         window_length: WIN_LEN_RST};
    logic signed [15:0] osc_re    = OSC_RE_RST;
    logic signed [15:0] osc_im    = OSC_IM_RST;
    logic [23:0]        tone_left = '0;
    logic [10:0]        win_pos   = '0;
    logic [14:0]        win_tab [TAB_DEPTH];
    bit                 win_loaded [TAB_DEPTH];

    t_out_rsp    expected_samples [$];
    t_out_rsp    want;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned stall_left     = 0;
    int unsigned send_idle_pct  = 11;
    int unsigned recv_idle_pct  = 60;

    function automatic longint round_shift(input longint x, input int sh);
        return (x + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [15:0] clamp16(input longint x);
        if (x > 32767) begin
            return 16'sd32767;
        end else if (x < -32768) begin
            return -16'sd32768;
        end
        return 16'(x);
    endfunction

    function automatic void rotate_osc();
        longint re;
        longint im;
        re = longint'(osc_re) * longint'($signed(cfg_shadow.step_cos))
           - longint'(osc_im) * longint'($signed(cfg_shadow.step_sin));
        im = longint'(osc_re) * longint'($signed(cfg_shadow.step_sin))
           + longint'(osc_im) * longint'($signed(cfg_shadow.step_cos));
        osc_re = clamp16(round_shift(re, 15));
        osc_im = clamp16(round_shift(im, 15));
    endfunction

    function automatic logic [14:0] envelope_at(input logic [10:0] pos);
        return 15'(round_shift(longint'(win_tab[pos]) * longint'(cfg_shadow.volume), 15));
    endfunction

    function automatic t_out_rsp shape_sample(input logic [14:0] amp);
        t_out_rsp rsp;
        longint   tre;
        longint   tim;
        tre = round_shift(longint'(osc_re) * longint'(amp), 15);
        tim = round_shift(longint'(osc_im) * longint'(amp), 15);
        rsp.i_sample    = clamp16(round_shift(tim * longint'($signed(cfg_shadow.iq_gain)), 14));
        rsp.q_sample    = clamp16(tre
                        + round_shift(tim * longint'($signed(cfg_shadow.iq_phase)), 15));
        rsp.tone_active = 1'b1;
        return rsp;
    endfunction

    function automatic t_out_rsp next_tone_sample(input logic [23:0] add);
        t_out_rsp    rsp;
        logic [24:0] sum;
        logic [14:0] amp;
        int unsigned eff_len;
        rsp       = '0;
        sum       = tone_left + add;
        tone_left = (sum > 25'h0FFFFFF) ? 24'hFFFFFF : sum[23:0];
        eff_len   = (cfg_shadow.window_length > TAB_DEPTH) ? TAB_DEPTH
                                                           : cfg_shadow.window_length;
        if (tone_left != 0) begin
            rotate_osc();
            if (win_pos < eff_len) begin
                amp     = envelope_at(win_pos);
                win_pos = win_pos + 1'b1;
            end else begin
                amp = cfg_shadow.volume;
            end
            tone_left = tone_left - 1'b1;
            rsp       = shape_sample(amp);
        end else if (win_pos != 0) begin
            rotate_osc();
            win_pos = win_pos - 1'b1;
            rsp     = shape_sample(envelope_at(win_pos));
        end
        return rsp;
    endfunction

    // number of table entries loaded from index zero up
    function automatic int unsigned loaded_prefix();
        int unsigned n;
        n = 0;
        while (n < TAB_DEPTH && win_loaded[n]) begin
            n++;
        end
        return n;
    endfunction

    function automatic logic [15:0] pick_window_len();
        int unsigned p;
        int unsigned top;
        p   = loaded_prefix();
        top = (p == TAB_DEPTH) ? 2047 : p;
        if ($urandom_range(99) < 80) begin
            return 16'($urandom_range(0, (p < 16) ? p : 16));
        end
        return 16'($urandom_range(0, top));
    endfunction

    // rotation step of magnitude at least about one, so the carrier never dies out
    function automatic logic [15:0] rand_unit_step();
        logic [15:0] m;
        m = 16'($urandom_range(23170, 32767));
        return $urandom_range(1) ? -m : m;
    endfunction

    function automatic logic [15:0] rand_volume();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) begin
            return 16'd0;
        end else if (r < 20) begin
            return 16'd32767;
        end
        return 16'($urandom_range(0, 32767));
    endfunction

    task automatic send_req(input logic mode, input logic [9:0] idx, input logic [14:0] val,
                            input logic [23:0] add);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid              = 1'b1;
        i_in_req.mode           = mode;
        i_in_req.window_index   = idx;
        i_in_req.window_value   = val;
        i_in_req.add_samples    = add;
        do @(posedge i_clk); while (!o_in_ready);
        if (mode == MODE_LOAD) begin
            win_tab[idx]    = val;
            win_loaded[idx] = 1'b1;
        end else begin
            expected_samples.push_back(next_tone_sample(add));
        end
    endtask

    task automatic send_tick(input logic [23:0] add);
        send_req(MODE_TICK, 10'($urandom), 15'($urandom), add);
    endtask

    task automatic send_load(input logic [9:0] idx, input logic [14:0] val);
        send_req(MODE_LOAD, idx, val, 24'($urandom));
    endtask

    task automatic wait_for_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_samples.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_VOLUME:        cfg_shadow.volume        = data[14:0];
            CFG_IQ_GAIN:       cfg_shadow.iq_gain       = data;
            CFG_IQ_PHASE:      cfg_shadow.iq_phase      = data;
            CFG_STEP_COS:      cfg_shadow.step_cos      = data;
            CFG_STEP_SIN:      cfg_shadow.step_sin      = data;
            CFG_WINDOW_LENGTH: cfg_shadow.window_length = data[10:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic write_all_regs(input logic [15:0] vol, input logic [15:0] gain,
                                  input logic [15:0] phase, input logic [15:0] s_cos,
                                  input logic [15:0] s_sin, input logic [15:0] len);
        wait_for_idle();
        write_reg(CFG_VOLUME, vol);
        write_reg(CFG_IQ_GAIN, gain);
        write_reg(CFG_IQ_PHASE, phase);
        write_reg(CFG_STEP_COS, s_cos);
        write_reg(CFG_STEP_SIN, s_sin);
        write_reg(CFG_WINDOW_LENGTH, len);
    endtask

    // defaults: no window, so a tone holds at full volume
    task automatic test_silent_after_reset();
        send_tick(24'd0);
        send_tick(24'd1);
        send_tick(24'd0);
    endtask

    task automatic test_window_ramp();
        send_load(10'd0, 15'd0);
        send_load(10'd1, 15'd32767);
        send_load(10'd2, 15'($urandom));
        send_load(10'd3, 15'($urandom));
        wait_for_idle();
        write_reg(CFG_WINDOW_LENGTH, 16'd4);
        send_tick(24'd2);
        repeat (4) send_tick(24'd0);
    endtask

    task automatic test_window_shortened();
        send_tick(24'd3);
        send_tick(24'd0);
        wait_for_idle();
        write_reg(CFG_WINDOW_LENGTH, 16'd1);
        repeat (3) send_tick(24'd0);
    endtask

    task automatic test_register_extremes();
        write_all_regs(16'd0, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'd4);
        send_tick(24'd1);
        send_tick(24'd0);
        write_all_regs(16'd32767, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'd0);
        send_tick(24'd1);
        send_tick(24'd0);
        write_all_regs(16'd1, 16'd0, 16'd0, 16'd0, 16'h7FFF, 16'd1);
        send_tick(24'd1);
        send_tick(24'd0);
    endtask

    // long window ramped fully up, held, and ramped fully down
    task automatic test_long_window();
        for (int i = 0; i < LONG_WIN; i++) begin
            send_load(10'(i), 15'($urandom));
        end
        write_all_regs(rand_volume(), 16'($urandom), 16'($urandom), rand_unit_step(),
                       rand_unit_step(), 16'(LONG_WIN));
        send_tick(24'(LONG_WIN + 6));
        repeat (2 * LONG_WIN + 6) send_tick(24'd0);
    endtask

    task automatic test_random_traffic(input int unsigned phases, input int unsigned per_phase);
        int unsigned r;
        logic [23:0] add;
        for (int p = 0; p < phases; p++) begin
            write_all_regs(rand_volume(), 16'($urandom), 16'($urandom), rand_unit_step(),
                           rand_unit_step(), pick_window_len());
            for (int n = 0; n < per_phase; n++) begin
                if ($urandom_range(99) < 20) begin
                    send_load(10'($urandom), 15'($urandom));
                end else begin
                    r   = $urandom_range(99);
                    add = (r < 55) ? 24'd0
                        : (r < 95) ? 24'($urandom_range(1, 12)) : 24'($urandom_range(13, 40));
                    send_tick(add);
                end
            end
        end
    endtask

    task automatic test_output_stall();
        send_tick(24'd8);
        stall_left = HOLD_CYCLES;
        repeat (40) send_tick(24'($urandom_range(0, 2)));
        wait_for_idle();
    endtask

    // runs last: once saturated, the count does not drain within the run
    task automatic test_count_saturation();
        write_all_regs(rand_volume(), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), pick_window_len());
        send_tick(24'hFFFFFF);
        send_tick(24'hFFFFFF);
        repeat (25) begin
            if ($urandom_range(99) < 25) begin
                send_load(10'($urandom), 15'($urandom));
            end else begin
                send_tick(24'($urandom));
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            i_out_ready = 1'b0;
            stall_left--;
        end else begin
            i_out_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_samples.size() == 0) begin
                $error("output request with none expected");
                mismatch_count++;
            end else begin
                want = expected_samples.pop_front();
                if (o_out_rsp.i_sample !== want.i_sample) begin
                    $error("i_sample: expected %0d, got %0d", want.i_sample,
                           o_out_rsp.i_sample);
                    mismatch_count++;
                end
                if (o_out_rsp.q_sample !== want.q_sample) begin
                    $error("q_sample: expected %0d, got %0d", want.q_sample,
                           o_out_rsp.q_sample);
                    mismatch_count++;
                end
                if (o_out_rsp.tone_active !== want.tone_active) begin
                    $error("tone_active: expected %0d, got %0d", want.tone_active,
                           o_out_rsp.tone_active);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $error("no request accepted for %0d cycles", quiet_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_silent_after_reset();
        test_window_ramp();
        test_window_shortened();
        test_register_extremes();
        test_long_window();
        test_random_traffic(4, 17);
        send_idle_pct = 60;
        recv_idle_pct = 11;
        test_random_traffic(4, 17);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(4, 17);
        test_output_stall();
        test_count_saturation();
        wait_for_idle();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
